[hdl/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants for the LFU cache
// Item layouts for both channels, field widths, opcodes and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int COUNT_W_DEF = 16;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                     op;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic signed [KEY_W-1:0]  evicted_key;
  } out_item_t;

  // outcome of one pass of the compare unit
  typedef struct packed {
    logic match;
    logic victim;
    logic free;
  } scan_flags_t;

endpackage

`default_nettype wire

[hdl/lfu_store.sv]
// ----------------------------------------------------------------------------
// lfu_store: entry storage for the LFU cache
// Key, data, use count and recency rank memories with registered reads,
// plus a valid flag per entry cleared at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_store #(
  parameter int MAX_ENTRIES = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_WIDTH = lfu_pkg::COUNT_W_DEF,
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [AW-1:0]                    rd_addr,
  output logic                                  rd_valid,
  output logic [lfu_pkg::KEY_W-1:0]             rd_key,
  output logic [lfu_pkg::DATA_W-1:0]            rd_data,
  output logic [COUNT_WIDTH-1:0]                rd_cnt,
  output logic [RW-1:0]                         rd_rank,
  input  wire logic [AW-1:0]                    wr_addr,
  input  wire logic                             valid_set,
  input  wire logic                             key_we,
  input  wire logic                             data_we,
  input  wire logic                             cnt_we,
  input  wire logic [lfu_pkg::KEY_W-1:0]        wr_key,
  input  wire logic [lfu_pkg::DATA_W-1:0]       wr_data,
  input  wire logic [COUNT_WIDTH-1:0]           wr_cnt,
  input  wire logic                             rank_we,
  input  wire logic [AW-1:0]                    rank_addr,
  input  wire logic [RW-1:0]                    rank_wdata
);

  logic [lfu_pkg::KEY_W-1:0]  key_mem  [MAX_ENTRIES];
  logic [lfu_pkg::DATA_W-1:0] data_mem [MAX_ENTRIES];
  logic [COUNT_WIDTH-1:0]     cnt_mem  [MAX_ENTRIES];
  logic [RW-1:0]              rank_mem [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0] valid_r;
  logic                   rd_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (valid_set) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (data_we) begin
      data_mem[wr_addr] <= wr_data;
    end
    if (cnt_we) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (rank_we) begin
      rank_mem[rank_addr] <= rank_wdata;
    end
    rd_key  <= key_mem[rd_addr];
    rd_data <= data_mem[rd_addr];
    rd_cnt  <= cnt_mem[rd_addr];
    rd_rank <= rank_mem[rd_addr];
  end

  assign rd_valid = rd_valid_r;

endmodule

`default_nettype wire

[hdl/lfu_scan.sv]
// ----------------------------------------------------------------------------
// lfu_scan: compare unit for the LFU cache
// Takes one entry per cycle while en is high and tracks the key match, the
// eviction candidate (lowest count, least recent among ties) and the first free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_scan #(
  parameter int MAX_ENTRIES = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_WIDTH = lfu_pkg::COUNT_W_DEF,
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic                        en,
  input  wire logic [AW-1:0]               idx,
  input  wire logic                        valid,
  input  wire logic [lfu_pkg::KEY_W-1:0]   key,
  input  wire logic [lfu_pkg::DATA_W-1:0]  data,
  input  wire logic [COUNT_WIDTH-1:0]      cnt,
  input  wire logic [RW-1:0]               rank,
  input  wire logic [lfu_pkg::KEY_W-1:0]   srch_key,
  output lfu_pkg::scan_flags_t             flags,
  output logic [AW-1:0]                    match_idx,
  output logic [COUNT_WIDTH-1:0]           match_cnt,
  output logic [RW-1:0]                    match_rank,
  output logic [lfu_pkg::DATA_W-1:0]       match_data,
  output logic [AW-1:0]                    vic_idx,
  output logic [RW-1:0]                    vic_rank,
  output logic [lfu_pkg::KEY_W-1:0]        vic_key,
  output logic [AW-1:0]                    free_idx
);

  lfu_pkg::scan_flags_t       flags_r, flags_nxt;
  logic [AW-1:0]              match_idx_r;
  logic [COUNT_WIDTH-1:0]     match_cnt_r;
  logic [RW-1:0]              match_rank_r;
  logic [lfu_pkg::DATA_W-1:0] match_data_r;
  logic [AW-1:0]              vic_idx_r;
  logic [COUNT_WIDTH-1:0]     vic_cnt_r;
  logic [RW-1:0]              vic_rank_r;
  logic [lfu_pkg::KEY_W-1:0]  vic_key_r;
  logic [AW-1:0]              free_idx_r;

  logic is_match, is_victim, is_free;

  always_comb begin
    is_match  = en && valid && (key == srch_key);
    is_victim = en && valid &&
                (!flags_r.victim || (cnt < vic_cnt_r) ||
                 ((cnt == vic_cnt_r) && (rank > vic_rank_r)));
    is_free   = en && !valid && !flags_r.free;
    flags_nxt = flags_r;
    if (start) begin
      flags_nxt = '0;
    end else begin
      if (is_match) begin
        flags_nxt.match = 1'b1;
      end
      if (is_victim) begin
        flags_nxt.victim = 1'b1;
      end
      if (is_free) begin
        flags_nxt.free = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_match) begin
      match_idx_r  <= idx;
      match_cnt_r  <= cnt;
      match_rank_r <= rank;
      match_data_r <= data;
    end
    if (is_victim) begin
      vic_idx_r  <= idx;
      vic_cnt_r  <= cnt;
      vic_rank_r <= rank;
      vic_key_r  <= key;
    end
    if (is_free) begin
      free_idx_r <= idx;
    end
  end

  assign flags      = flags_r;
  assign match_idx  = match_idx_r;
  assign match_cnt  = match_cnt_r;
  assign match_rank = match_rank_r;
  assign match_data = match_data_r;
  assign vic_idx    = vic_idx_r;
  assign vic_rank   = vic_rank_r;
  assign vic_key    = vic_key_r;
  assign free_idx   = free_idx_r;

endmodule

`default_nettype wire

[hdl/lfu_cache_with_lru_tiebreak.sv]
// ----------------------------------------------------------------------------
// lfu_cache_with_lru_tiebreak: fully associative LFU key/value cache
// Gets and puts with least-frequently-used replacement, least recent first
// among equal use counts.
//
// Usage:
//   in_valid/in_stall/in_data carry one access (op, key, value); a transfer
//   takes place when in_valid is high and in_stall low. out_valid/out_stall/
//   out_data return one result per access: hit, read_value, evicted and
//   evicted_key. cfg_we/cfg_wdata write the capacity register; write it only
//   while no access is in flight.
//   Each access runs through one compare unit that reads one entry per cycle:
//   a search pass, a decision step and, when the recency order changes, a
//   rank pass; a get miss or an ignored put skips the rank pass. One access
//   is in flight at a time; a new one is taken the cycle after the result is
//   registered, even while that result is stalled. A stalled result holds;
//   a finished access then waits until it can load. Reset empties the cache
//   and sets capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_with_lru_tiebreak #(
  parameter int MAX_ENTRIES = lfu_pkg::ENTRIES_DEF,
  parameter int COUNT_WIDTH = lfu_pkg::COUNT_W_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire lfu_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output lfu_pkg::out_item_t              out_data,
  input  wire logic                       cfg_we,
  input  wire logic [lfu_pkg::CAP_W-1:0]  cfg_wdata
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int IW = $clog2(MAX_ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_RANK   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic                          cmp_en_r;
  logic [AW-1:0]                 cmp_idx_r;
  logic [lfu_pkg::CAP_W-1:0]     cap_r;
  logic [IW-1:0]                 occ_r;
  lfu_pkg::in_item_t             item_r;
  lfu_pkg::out_item_t            res_r;
  lfu_pkg::out_item_t            out_data_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [AW-1:0]                 upd_slot_r;
  logic [RW-1:0]                 thr_r;
  logic                          all_r;

  logic                          in_xfer, walking, last_step, out_load;
  logic [AW-1:0]                 rd_addr;

  // store read side
  logic                          rd_valid;
  logic [lfu_pkg::KEY_W-1:0]     rd_key;
  logic [lfu_pkg::DATA_W-1:0]    rd_data;
  logic [COUNT_WIDTH-1:0]        rd_cnt;
  logic [RW-1:0]                 rd_rank;

  // compare unit results
  lfu_pkg::scan_flags_t          flags;
  logic [AW-1:0]                 match_idx, vic_idx, free_idx;
  logic [COUNT_WIDTH-1:0]        match_cnt;
  logic [RW-1:0]                 match_rank, vic_rank;
  logic [lfu_pkg::DATA_W-1:0]    match_data;
  logic [lfu_pkg::KEY_W-1:0]     vic_key;

  // decision
  logic                          cap_zero, cap_big, full;
  logic                          dec_upd, dec_all, dec_insert, dec_grow;
  logic                          dec_data_we, dec_cnt_we;
  logic [AW-1:0]                 dec_slot;
  logic [RW-1:0]                 dec_thr;
  logic [COUNT_WIDTH-1:0]        dec_cnt;
  lfu_pkg::out_item_t            dec_res;
  logic                          in_decide;

  // rank pass
  logic                          rank_we;
  logic [RW-1:0]                 rank_wdata;

  assign in_xfer   = (state_r == S_IDLE) && in_valid;
  assign walking   = (state_r == S_SCAN) || (state_r == S_RANK);
  assign last_step = (idx_r == LAST_IDX);
  assign rd_addr   = idx_r[AW-1:0];
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign in_decide = (state_r == S_DECIDE);

  // -------------------------------------------------------------------------
  // decision from the search pass
  // -------------------------------------------------------------------------
  always_comb begin
    cap_zero = (cap_r == '0);
    cap_big  = (32'(cap_r) > 32'(MAX_ENTRIES));
    full     = (32'(occ_r) >= (cap_big ? 32'(MAX_ENTRIES) : 32'(cap_r)));

    dec_upd     = 1'b0;
    dec_all     = 1'b0;
    dec_insert  = 1'b0;
    dec_grow    = 1'b0;
    dec_data_we = 1'b0;
    dec_cnt_we  = 1'b0;
    dec_slot    = match_idx;
    dec_thr     = match_rank;
    dec_cnt     = (match_cnt == '1) ? match_cnt : match_cnt + COUNT_WIDTH'(1);

    dec_res             = '0;
    dec_res.hit         = flags.match;

    if (item_r.op == lfu_pkg::OP_GET) begin
      if (flags.match) begin
        dec_upd            = 1'b1;
        dec_cnt_we         = 1'b1;
        dec_res.read_value = match_data;
      end else begin
        dec_res.read_value = '1;
      end
    end else if (!cap_zero) begin
      dec_data_we = 1'b1;
      dec_cnt_we  = 1'b1;
      dec_upd     = 1'b1;
      if (!flags.match) begin
        dec_insert = 1'b1;
        dec_cnt    = COUNT_WIDTH'(1);
        if (full) begin
          // reuse the victim's slot; ranks above it stay, those below shift
          dec_slot            = vic_idx;
          dec_thr             = vic_rank;
          dec_res.evicted     = 1'b1;
          dec_res.evicted_key = vic_key;
        end else begin
          dec_slot = free_idx;
          dec_all  = 1'b1;
          dec_grow = 1'b1;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (last_step) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_DECIDE: begin
        idx_nxt   = '0;
        state_nxt = dec_upd ? S_RANK : S_DONE;
      end
      S_RANK: begin
        if (last_step) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      cmp_en_r    <= 1'b0;
      cap_r       <= lfu_pkg::CAP_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cmp_en_r    <= walking && !last_step;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (in_decide && dec_grow) begin
        occ_r <= occ_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_addr;
    if (in_xfer) begin
      item_r <= in_data;
    end
    if (in_decide) begin
      res_r      <= dec_res;
      upd_slot_r <= dec_slot;
      thr_r      <= dec_thr;
      all_r      <= dec_all;
    end
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  // -------------------------------------------------------------------------
  // rank pass: the touched slot becomes rank 0, more recent entries (all, on an insert into a free slot) advance
  // -------------------------------------------------------------------------
  always_comb begin
    rank_we = (state_r == S_RANK) && cmp_en_r && rd_valid;
    if (cmp_idx_r == upd_slot_r) begin
      rank_wdata = '0;
    end else if (all_r || (rd_rank < thr_r)) begin
      rank_wdata = rd_rank + RW'(1);
    end else begin
      rank_wdata = rd_rank;
    end
  end

  lfu_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_addr    (rd_addr),
    .rd_valid   (rd_valid),
    .rd_key     (rd_key),
    .rd_data    (rd_data),
    .rd_cnt     (rd_cnt),
    .rd_rank    (rd_rank),
    .wr_addr    (dec_slot),
    .valid_set  (in_decide && dec_insert),
    .key_we     (in_decide && dec_insert),
    .data_we    (in_decide && dec_data_we),
    .cnt_we     (in_decide && dec_cnt_we),
    .wr_key     (item_r.key),
    .wr_data    (item_r.value),
    .wr_cnt     (dec_cnt),
    .rank_we    (rank_we),
    .rank_addr  (cmp_idx_r),
    .rank_wdata (rank_wdata)
  );

  lfu_scan #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_xfer),
    .en         ((state_r == S_SCAN) && cmp_en_r),
    .idx        (cmp_idx_r),
    .valid      (rd_valid),
    .key        (rd_key),
    .data       (rd_data),
    .cnt        (rd_cnt),
    .rank       (rd_rank),
    .srch_key   (item_r.key),
    .flags      (flags),
    .match_idx  (match_idx),
    .match_cnt  (match_cnt),
    .match_rank (match_rank),
    .match_data (match_data),
    .vic_idx    (vic_idx),
    .vic_rank   (vic_rank),
    .vic_key    (vic_key),
    .free_idx   (free_idx)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[sim/tb_lfu_cache_with_lru_tiebreak.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lfu_cache_with_lru_tiebreak: self-checking bench for the LFU cache
// Feeds gets and puts through the input channel and predicts every result
// with a local LFU/LRU cache model. Checks each result field by field.
// Runs a directed opening and then random phases over several capacity
// settings: zero, one, small, full, above the table size, and lowered below
// occupancy. The phases take turns among four patterns of sender gaps and receiver
// stalls. The use counters are built narrow so that saturation is reached.
// ----------------------------------------------------------------------------

module tb_lfu_cache_with_lru_tiebreak;
  import lfu_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;
  // narrow use counters so that saturation happens within a short run
  localparam int USE_W = 4;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int POOL_N = 24;
  localparam int PHASE_ITEMS = 200;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  lfu_cache_with_lru_tiebreak #(
    .MAX_ENTRIES (ENTRIES),
    .COUNT_WIDTH (USE_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  in_item_t  access_q[$];
  out_item_t result_q[$];
  out_item_t want_res;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int n_cycles = 0;
  int n_accesses = 0;
  int n_checked = 0;
  int n_hits = 0;
  int n_evictions = 0;
  int n_cap_writes = 0;
  int n_errors = 0;

  logic signed [KEY_W-1:0] key_pool [POOL_N];

  // cache contents as the block should hold them
  logic                     c_valid [ENTRIES];
  logic signed [KEY_W-1:0]  c_key   [ENTRIES];
  logic signed [DATA_W-1:0] c_data  [ENTRIES];
  logic [USE_W-1:0]         c_uses  [ENTRIES];
  int                       c_rank  [ENTRIES];
  int                       c_fill;
  logic [CAP_W-1:0]         c_capacity = CAP_RESET;

  // make slot s the most recent and count one more use, saturating
  function automatic void bump(int s);
    for (int i = 0; i < ENTRIES; i++)
      if (c_valid[i] && c_rank[i] < c_rank[s]) c_rank[i]++;
    c_rank[s] = 0;
    if (c_uses[s] != {USE_W{1'b1}}) c_uses[s]++;
  endfunction

  function automatic out_item_t cache_access(in_item_t req);
    out_item_t res;
    int slot;
    int vic;
    int lim;
    res = '0;
    slot = -1;
    vic = -1;
    lim = (c_capacity > ENTRIES) ? ENTRIES : int'(c_capacity);
    for (int i = 0; i < ENTRIES; i++)
      if (slot < 0 && c_valid[i] && c_key[i] == req.key) slot = i;
    res.hit = (slot >= 0);
    if (req.op == OP_GET) begin
      if (slot >= 0) begin
        bump(slot);
        res.read_value = c_data[slot];
      end else begin
        res.read_value = '1;
      end
    end else if (lim != 0) begin
      if (slot >= 0) begin
        c_data[slot] = req.value;
        bump(slot);
      end else begin
        if (c_fill >= lim) begin
          // fewest uses first, least recent among equals
          for (int i = 0; i < ENTRIES; i++)
            if (c_valid[i] && (vic < 0 || c_uses[i] < c_uses[vic] ||
                (c_uses[i] == c_uses[vic] && c_rank[i] > c_rank[vic])))
              vic = i;
          if (vic >= 0) begin
            res.evicted = 1'b1;
            res.evicted_key = c_key[vic];
            c_valid[vic] = 1'b0;
            for (int i = 0; i < ENTRIES; i++)
              if (c_valid[i] && c_rank[i] > c_rank[vic]) c_rank[i]--;
            c_fill--;
            slot = vic;
          end
        end
        if (slot < 0)
          for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && !c_valid[i]) slot = i;
        if (slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (c_valid[i]) c_rank[i]++;
          c_valid[slot] = 1'b1;
          c_key[slot] = req.key;
          c_data[slot] = req.value;
          c_uses[slot] = USE_W'(1);
          c_rank[slot] = 0;
          c_fill++;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    if (n_errors <= 40)
      $display("mismatch at result %0d: %s got %h expected %h",
               n_checked, what, got, want);
  endtask

  // driver: hold the payload until the transfer, then predict its result
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        result_q.push_back(cache_access(in_data));
        n_accesses++;
      end
      if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= access_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_data.read_value, 0);
        end else begin
          want_res = result_q.pop_front();
          if (out_data.hit !== want_res.hit)
            report_mismatch("hit", 32'(out_data.hit), 32'(want_res.hit));
          if (out_data.read_value !== want_res.read_value)
            report_mismatch("read_value", out_data.read_value, want_res.read_value);
          if (out_data.evicted !== want_res.evicted)
            report_mismatch("evicted", 32'(out_data.evicted), 32'(want_res.evicted));
          if (out_data.evicted_key !== want_res.evicted_key)
            report_mismatch("evicted_key", out_data.evicted_key, want_res.evicted_key);
          if (want_res.hit) n_hits++;
          if (want_res.evicted) n_evictions++;
          n_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // wait until every queued access has been transferred and answered
  task automatic settle();
    do @(negedge clk);
    while (access_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    c_capacity = v;
    n_cap_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_item(input logic op, input logic [31:0] k, input logic [31:0] v);
    in_item_t it;
    it.op = op;
    it.key = k;
    it.value = v;
    access_q.push_back(it);
  endtask

  task automatic run_random(input logic [CAP_W-1:0] cap, input int idle_p,
                            input int stall_p, input int n);
    in_item_t it;
    int eff;
    int pn;
    int idx;
    int alt;
    settle();
    set_capacity(cap);
    @(negedge clk);
    send_idle_pct = idle_p;
    stall_pct = stall_p;
    eff = (cap > ENTRIES) ? ENTRIES : int'(cap);
    pn = (eff == 0) ? 20 : eff + 2 + $urandom_range(4);
    if (pn > POOL_N) pn = POOL_N;
    // refresh part of the pool, keep the extreme keys in front
    for (int i = 4; i < POOL_N; i++)
      if ($urandom_range(3) == 0) key_pool[i] = $urandom;
    repeat (n) begin
      it.op = ($urandom_range(99) < 55) ? OP_PUT : OP_GET;
      if ($urandom_range(99) < 8) begin
        it.key = $urandom;
      end else begin
        // skew towards the front so some entries get used heavily
        idx = $urandom_range(pn - 1);
        alt = $urandom_range(pn - 1);
        it.key = key_pool[(alt < idx) ? alt : idx];
      end
      case ($urandom_range(15))
        0: it.value = -1;
        1: it.value = 0;
        2: it.value = 32'h7FFF_FFFF;
        3: it.value = 32'h8000_0000;
        default: it.value = $urandom;
      endcase
      access_q.push_back(it);
    end
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      c_valid[i] = 1'b0;
      c_key[i] = '0;
      c_data[i] = '0;
      c_uses[i] = '0;
      c_rank[i] = 0;
    end
    c_fill = 0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = -1;
    key_pool[3] = 0;
    for (int i = 4; i < POOL_N; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_capacity(CAP_RESET);
    @(negedge clk);

    // directed opening: empty miss, extremes, update, fill, LRU tie-break evictions
    add_item(OP_GET, 0, 0);
    add_item(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    add_item(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    add_item(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(OP_PUT, 0, 0);
    add_item(OP_GET, 32'h8000_0000, 0);
    add_item(OP_GET, 32'hFFFF_FFFF, 32'h1234_5678);
    add_item(OP_PUT, 32'h7FFF_FFFF, 32'h5A5A_A5A5);
    add_item(OP_GET, 32'h7FFF_FFFF, 0);
    for (int i = 0; i < 12; i++) add_item(OP_PUT, 100 + i, ~i);
    add_item(OP_PUT, 32'h0000_1234, 32'hDEAD_BEEF);
    add_item(OP_GET, 100, 0);
    add_item(OP_PUT, 32'h0000_5555, 1);
    add_item(OP_GET, 0, 0);

    run_random(16, 0, 0, PHASE_ITEMS);
    run_random(0, 80, 0, PHASE_ITEMS);
    run_random(3, 0, 80, PHASE_ITEMS);
    run_random(1, 28, 28, PHASE_ITEMS);
    run_random(31, 0, 0, PHASE_ITEMS);
    run_random(7, 80, 0, PHASE_ITEMS);
    run_random(17, 0, 80, PHASE_ITEMS);
    run_random(16, 28, 28, PHASE_ITEMS);
    settle();
    repeat (40) @(posedge clk);

    if (result_q.size() != 0)
      report_mismatch("results never returned", result_q.size(), 0);
    $display("%0d accesses over %0d capacity settings, %0d results checked",
             n_accesses, n_cap_writes, n_checked);
    $display("%0d hits, %0d evictions, %0d mismatches", n_hits, n_evictions, n_errors);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
